>>> sv/pus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types, constants and the fixed-point log2 helpers for the
// uncertainty statistics block.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int unsigned ONE_Q16 = 65536;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic CFG_ENTROPY_LIMIT    = 1'b0;
  localparam logic CFG_CONFIDENCE_LIMIT = 1'b1;

  // Totals of one finished vector, handed from the front to the back.
  typedef struct packed {
    logic [31:0] sum;
    logic [16:0] best;
    logic [16:0] second;
    logic [16:0] count;
    logic        over;
  } vec_t;

  // T[i] = log2(1 + i/2^fb) in Q0.16 by repeated squaring; elaboration only.
  function automatic logic [15:0] frac_log2(input int unsigned i, input int unsigned fb);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'(1 << fb) + 64'(i)) << (30 - fb);
    r = '0;
    for (int b = 0; b < 16; b++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  // Leading-one position of a nonzero 17-bit value.
  function automatic logic [4:0] lead_one(input logic [16:0] v);
    logic [4:0] k;
    k = '0;
    for (int s = 1; s <= 16; s++) begin
      if (v[s]) k = 5'(s);
    end
    return k;
  endfunction

endpackage

>>> sv/pus_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_front
// Accepts probabilities at one per cycle while in_ready is high, forms each
// entropy term in a short pipeline and accumulates sum, top two and count.
// A closed vector is pushed into the queue toward the back stage.
// ----------------------------------------------------------------------------
module pus_front import pus_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 4096,
  parameter int unsigned FB        = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] prob,
  input  logic        last,
  output logic        q_push,
  output vec_t        q_data,
  input  logic        q_space
);

  localparam int unsigned TN = 1 << FB;

  logic [15:0] ftab [TN];
  for (genvar g = 0; g < TN; g++) begin : g_tab
    assign ftab[g] = frac_log2(g, FB);
  end

  // stage 1: clamp, log2
  logic        s1_v, s1_last;
  logic [16:0] s1_p;
  logic [20:0] s1_neg;
  // stage 2: product
  logic        s2_v, s2_last;
  logic [16:0] s2_p;
  logic [20:0] s2_term;

  logic [31:0] sum;
  logic [16:0] best, second, count;
  logic        over;

  // Stall intake while the queue lacks space for all closes in flight.
  assign in_ready = q_space;

  logic        acc;
  logic [16:0] pc;
  logic [4:0]  k;
  logic [16:0] m;
  logic [FB-1:0] idx;
  logic [20:0] lg;

  assign acc = in_valid && in_ready;

  always_comb begin
    pc = (prob > 17'(ONE_Q16)) ? 17'(ONE_Q16) : prob;
    k  = lead_one(pc);
    m  = pc & ~(17'd1 << k);
    if (32'(k) >= FB) idx = FB'(m >> (32'(k) - FB));
    else              idx = FB'(m << (FB - 32'(k)));
    lg = {k, 16'd0} + 21'(ftab[idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= acc;
      s2_v <= s1_v;
    end
    s1_p    <= pc;
    s1_last <= last;
    s1_neg  <= 21'(16 * ONE_Q16) - lg;
    s2_p    <= s1_p;
    s2_last <= s1_last;
    s2_term <= (s1_p == '0) ? '0 : 21'((38'(s1_p) * 38'(s1_neg)) >> 16);
  end

  logic [32:0] sum_w;
  logic [31:0] sum_next;
  logic [16:0] best_next, second_next, count_next;
  logic        over_next;

  always_comb begin
    sum_w    = 33'(sum) + 33'(s2_term);
    sum_next = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
    best_next   = best;
    second_next = second;
    if (s2_p > best) begin
      second_next = best;
      best_next   = s2_p;
    end else if (s2_p > second) begin
      second_next = s2_p;
    end
    count_next = count;
    over_next  = over;
    if (count < 17'(MAX_ITEMS)) count_next = count + 17'd1;
    else                        over_next  = 1'b1;
  end

  assign q_push = s2_v && s2_last;
  assign q_data = '{sum: sum_next, best: best_next, second: second_next,
                    count: count_next, over: over_next};

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      sum <= '0; best <= '0; second <= '0; count <= '0; over <= 1'b0;
    end else if (s2_v) begin
      sum <= sum_next; best <= best_next; second <= second_next;
      count <= count_next; over <= over_next;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= 17'(MAX_ITEMS)) else $error("count past cap");
  a_order: assert property (@(posedge clk) disable iff (rst)
    second <= best) else $error("top two out of order");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_v) else $error("stage 1 lost an item");

endmodule

>>> sv/pus_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_back
// Holds a small queue of closed vectors and finishes one at a time: nats by
// a multiply, normalized entropy by a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module pus_back import pus_pkg::*; #(
  parameter int unsigned FB = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_push,
  input  vec_t        q_data,
  output logic        q_space,
  input  logic [16:0] entropy_limit,
  input  logic [16:0] confidence_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] entropy_nats,
  output logic [16:0] norm_entropy,
  output logic [16:0] top_prob,
  output logic [16:0] top_margin,
  output logic        uncertain,
  output logic        length_over
);

  localparam int unsigned TN = 1 << FB;
  localparam int unsigned QD = 4;

  logic [15:0] ftab [TN];
  for (genvar g = 0; g < TN; g++) begin : g_tab
    assign ftab[g] = frac_log2(g, FB);
  end

  vec_t       qm [QD];
  logic [1:0] wp, rp;
  logic [2:0] fill;
  logic       pop;

  // Up to three more closes can be in the front pipeline.
  assign q_space = fill < 3'(QD - 3);

  typedef enum logic [1:0] {IDLE, DIV, DONE} st_t;
  st_t         st;
  vec_t        cur;
  logic [48:0] rem;
  logic [47:0] dvd;
  logic [20:0] dvs;
  logic [5:0]  bitn;
  logic [47:0] quo;
  logic [47:0] nats_p;

  logic [4:0]    k;
  logic [16:0]   m;
  logic [FB-1:0] idx;
  logic [20:0]   lgc;

  always_comb begin
    k  = lead_one(qm[rp].count);
    m  = qm[rp].count & ~(17'd1 << k);
    if (32'(k) >= FB) idx = FB'(m >> (32'(k) - FB));
    else              idx = FB'(m << (FB - 32'(k)));
    lgc = {k, 16'd0} + 21'(ftab[idx]);
  end

  assign pop = (st == IDLE) && (fill != '0);

  always_ff @(posedge clk) begin
    if (q_push) qm[wp] <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (q_push) wp <= wp + 2'd1;
      if (pop)    rp <= rp + 2'd1;
      fill <= fill + 3'(q_push) - 3'(pop);
    end
  end

  logic [49:0] trial;
  assign trial = {rem, dvd[47]} - {29'd0, dvs};

  logic [16:0] norm_v;
  logic [47:0] nats_s;
  assign norm_v = (cur.count <= 17'd1) ? '0 :
                  (quo > 48'(ONE_Q16)) ? 17'(ONE_Q16) : quo[16:0];
  assign nats_s = nats_p >> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (st)
        IDLE: begin
          if (pop) begin
            cur    <= qm[rp];
            dvd    <= {qm[rp].sum, 16'd0};
            dvs    <= lgc;
            rem    <= '0;
            quo    <= '0;
            bitn   <= 6'd48;
            nats_p <= 48'(qm[rp].sum) * 48'(LN2_Q16);
            st     <= DIV;
          end
        end
        DIV: begin
          // shift one dividend bit in, subtract if it fits
          if (!trial[49]) begin
            rem <= trial[48:0];
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= {rem[47:0], dvd[47]};
            quo <= {quo[46:0], 1'b0};
          end
          dvd  <= dvd << 1;
          bitn <= bitn - 6'd1;
          if (bitn == 6'd1) st <= DONE;
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            entropy_nats <= (nats_s > 48'hFFFFF) ? 20'hFFFFF : nats_s[19:0];
            norm_entropy <= norm_v;
            top_prob     <= cur.best;
            top_margin   <= (cur.count <= 17'd1) ? cur.best : cur.best - cur.second;
            uncertain    <= (norm_v >= entropy_limit) || (cur.best <= confidence_limit);
            length_over  <= cur.over;
            out_valid    <= 1'b1;
            st           <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
      if (out_valid && out_ready && !(st == DONE)) out_valid <= 1'b0;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> fill < 3'(QD)) else $error("queue overrun");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0) else $error("pop from empty queue");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (st == DIV) |-> bitn != '0) else $error("divider count underflow");

endmodule

>>> sv/prediction_uncertainty_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prediction_uncertainty_stats
// Entropy, top-two margin and uncertainty flag over a streamed vector.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one Q1.16 probability per
// transaction with a last marker. in_ready is high only while the four-entry
// vector queue is empty. Each finished vector therefore holds intake until
// the back stage pops it, also when it is queued behind one in progress.
// Each element passes a two-stage term pipeline into the accumulator, and a
// last element is pushed into the queue from stage 2. The back stage pops a
// vector, divides entropy by log2 of the count with a 48-step restoring
// divider and loads the output register. It finishes one vector before it
// pops the next. Results leave on out_valid/out_ready. The output register
// holds while the receiver stalls, and the back stage waits in its final
// step. Configuration writes (cfg_we, cfg_index, cfg_data) are registered
// into the thresholds. Synchronous reset clears accumulators, queue and
// handshakes and restores the thresholds.
// ----------------------------------------------------------------------------
module prediction_uncertainty_stats import pus_pkg::*; #(
  parameter int unsigned MAX_ITEMS           = 4096,
  parameter int unsigned FRACTION_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] prob,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] entropy_nats,
  output logic [16:0] norm_entropy,
  output logic [16:0] top_prob,
  output logic [16:0] top_margin,
  output logic        uncertain,
  output logic        length_over
);

  logic [16:0] entropy_limit, confidence_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      entropy_limit    <= 17'(ONE_Q16);
      confidence_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTROPY_LIMIT:    entropy_limit    <= cfg_data;
        CFG_CONFIDENCE_LIMIT: confidence_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_push, q_space;
  vec_t q_data;

  pus_front #(.MAX_ITEMS(MAX_ITEMS), .FB(FRACTION_TABLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .prob, .last,
    .q_push, .q_data, .q_space
  );

  pus_back #(.FB(FRACTION_TABLE_BITS)) u_back (
    .clk, .rst, .q_push, .q_data, .q_space, .entropy_limit, .confidence_limit,
    .out_valid, .out_ready, .entropy_nats, .norm_entropy, .top_prob,
    .top_margin, .uncertain, .length_over
  );

endmodule
